FILE: src/scwa_pkg.sv
// shared types, constants and helpers of the strip-chart window autoscale block
// no dependencies; every other file depends on this package
package scwa_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int IDX_BITS    = $clog2(MAX_WIDTH);
  localparam int FILL_BITS   = IDX_BITS + 1;
  localparam int COST_BITS   = 32;
  localparam int EPOCH_BITS  = 16;
  localparam int ROW_BITS    = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int SCALE_BITS  = 11;
  localparam int VIEW_BITS   = 34;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int ADDR_BITS   = 5;

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = HEIGHT_BITS'(2);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = HEIGHT_BITS'(4096);

  // register indexes on the config port
  localparam logic [2:0] REG_WINDOW_WIDTH = 3'd0;
  localparam logic [2:0] REG_PLOT_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_INFLATE      = 3'd2;
  localparam logic [2:0] REG_GMIN_SEED    = 3'd3;
  localparam logic [2:0] REG_GMAX_SEED    = 3'd4;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_RENDER = 2'd2
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [COST_BITS-1:0] cost;
    logic                 set;   // epoch tag is nonzero
  } cmd_t;

  typedef struct packed {
    logic [FILL_BITS-1:0]   width;
    logic [HEIGHT_BITS-1:0] height;
    logic [SCALE_BITS-1:0]  scale;
    logic [COST_BITS-1:0]   gmin_seed;
    logic [COST_BITS-1:0]   gmax_seed;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_DEC,
    ST_SCAN,
    ST_VIEW_MUL,
    ST_VIEW_INFL,
    ST_VIEW_BND,
    ST_PUSH_WR,
    ST_MAP_ROW,
    ST_MAP_MIN,
    ST_REN_RD,
    ST_REN_WAIT,
    ST_EMIT
  } core_state_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MUL,
    MS_ADD,
    MS_DIV
  } map_state_t;

  function automatic logic [FILL_BITS-1:0] eff_width(input logic [FILL_BITS-1:0] w);
    logic [FILL_BITS-1:0] r;
    r = w;
    if (w == '0) r = FILL_BITS'(1);
    if (w > FILL_BITS'(MAX_WIDTH)) r = FILL_BITS'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] h);
    logic [HEIGHT_BITS-1:0] r;
    r = h;
    if (h < HEIGHT_MIN) r = HEIGHT_MIN;
    if (h > HEIGHT_MAX) r = HEIGHT_MAX;
    return r;
  endfunction

endpackage

FILE: src/scwa_if.sv
// valid/ready channel interfaces for input words and result words
// depends on scwa_pkg for field widths
interface scwa_item_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      func;
  logic [scwa_pkg::COST_BITS-1:0]  cost;
  logic [scwa_pkg::EPOCH_BITS-1:0] epoch;
  modport source (output valid, func, cost, epoch, input ready);
  modport sink   (input valid, func, cost, epoch, output ready);
endinterface

interface scwa_result_if;
  logic                           valid;
  logic                           ready;
  logic [scwa_pkg::ROW_BITS-1:0]  row;
  logic [scwa_pkg::ROW_BITS-1:0]  min_row;
  logic [scwa_pkg::COST_BITS-1:0] local_min_cost;
  logic [scwa_pkg::COST_BITS-1:0] local_max_cost;
  logic [scwa_pkg::COST_BITS-1:0] global_min_cost;
  logic [scwa_pkg::COST_BITS-1:0] global_max_cost;
  logic                           last;
  modport source (output valid, row, min_row, local_min_cost, local_max_cost,
                  global_min_cost, global_max_cost, last, input ready);
  modport sink   (input valid, row, min_row, local_min_cost, local_max_cost,
                  global_min_cost, global_max_cost, last, output ready);
endinterface

FILE: src/strip_chart_window_autoscale_unit.sv
// top level: config registers on the apb port, front end, back end
// depends on scwa_pkg, scwa_if, scwa_front and scwa_core
//
// usage: input words (func, cost, epoch) arrive on the item channel, result
// words leave on the result channel, both valid/ready. func 0 pushes a
// sample and gives one word, func 1 clears and gives one word, func 2
// renders one word per stored sample, oldest first, the last one flagged.
// other func codes are taken and dropped. up to two words wait in a queue
// in front of the back end, so the item channel stays ready while a word
// is being worked on.
// each row mapping runs in the shared divider unit. an eviction of a
// sample at or beyond the window min or max, or of the only sample,
// rescans the window. a render maps the marker row first and then
// each sample in turn.
// the result register holds a word while the receiver stalls and the back
// end waits on it. reset clears the window, bounds and view; the ring
// contents are not cleared and are never read before being written.
// the user must write config only while idle; the block does not enforce it.
module strip_chart_window_autoscale_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scwa_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  scwa_item_if.sink                        item,
  scwa_result_if.source                    result
);
  import scwa_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_clear;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];
  assign cfg_clear = cfg_wr && (cfg_idx == REG_WINDOW_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width     <= FILL_BITS'(MAX_WIDTH);
      cfg.height    <= HEIGHT_BITS'(256);
      cfg.scale     <= SCALE_BITS'(307);
      cfg.gmin_seed <= '0;
      cfg.gmax_seed <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_WIDTH: cfg.width     <= pwdata[FILL_BITS-1:0];
        REG_PLOT_HEIGHT:  cfg.height    <= pwdata[HEIGHT_BITS-1:0];
        REG_INFLATE:      cfg.scale     <= pwdata[SCALE_BITS-1:0];
        REG_GMIN_SEED:    cfg.gmin_seed <= pwdata[COST_BITS-1:0];
        REG_GMAX_SEED:    cfg.gmax_seed <= pwdata[COST_BITS-1:0];
        default:          cfg.width     <= cfg.width;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_WIDTH: prdata = 32'(cfg.width);
      REG_PLOT_HEIGHT:  prdata = 32'(cfg.height);
      REG_INFLATE:      prdata = 32'(cfg.scale);
      REG_GMIN_SEED:    prdata = 32'(cfg.gmin_seed);
      REG_GMAX_SEED:    prdata = 32'(cfg.gmax_seed);
      default:          prdata = '0;
    endcase
  end

  scwa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  scwa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res       (result)
  );

endmodule

FILE: src/scwa_front.sv
// front end: accepts input words, decodes the function, queues commands
// depends on scwa_pkg and scwa_item_if
module scwa_front (
  input  logic            clk,
  input  logic            rst,
  scwa_item_if.sink       item,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output scwa_pkg::cmd_t  cmd
);
  import scwa_pkg::*;

  cmd_t                 queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 known;
  op_t                  op_dec;
  logic                 push;
  logic                 pop;

  always_comb begin
    known  = 1'b1;
    op_dec = OP_PUSH;
    case (item.func)
      OP_PUSH:   op_dec = OP_PUSH;
      OP_CLEAR:  op_dec = OP_CLEAR;
      OP_RENDER: op_dec = OP_RENDER;
      default:   known  = 1'b0;
    endcase
  end

  assign item.ready = (count < (QPTR_BITS+1)'(QUEUE_DEPTH));
  // unknown functions are taken and dropped here
  assign push      = item.valid && item.ready && known;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: op_dec, cost: item.cost, set: (item.epoch != '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/scwa_rowmap.sv
// row mapper: clamps a cost into the view and scales it to a pixel row
// one multiply then a 12-step restoring divide; depends on scwa_pkg
module scwa_rowmap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [scwa_pkg::COST_BITS-1:0]        d,
  input  logic signed [scwa_pkg::VIEW_BITS-1:0] lo,
  input  logic signed [scwa_pkg::VIEW_BITS-1:0] hi,
  input  logic [scwa_pkg::HEIGHT_BITS-1:0]      height,
  output logic                                  done,
  output logic [scwa_pkg::ROW_BITS-1:0]         row
);
  import scwa_pkg::*;

  localparam int RNG_BITS  = VIEW_BITS + 1;
  localparam int PROD_BITS = RNG_BITS + ROW_BITS;
  localparam int NUM_BITS  = PROD_BITS + 2;
  localparam int STEP_BITS = $clog2(ROW_BITS);

  map_state_t                 mstate;
  map_state_t                 mstate_next;
  logic [RNG_BITS-1:0]        diff;
  logic [RNG_BITS-1:0]        rng_q;
  logic [PROD_BITS-1:0]       prod;
  logic [NUM_BITS-1:0]        num;
  logic [PROD_BITS-1:0]       dvs;
  logic [ROW_BITS-1:0]        quo;
  logic [STEP_BITS-1:0]       step;
  logic [ROW_BITS-1:0]        hm1;
  logic signed [RNG_BITS:0]   ds;
  logic signed [RNG_BITS:0]   lo_x;
  logic signed [RNG_BITS:0]   hi_x;
  logic signed [RNG_BITS:0]   rng_x;
  logic signed [RNG_BITS:0]   diff_x;
  logic                       ge;

  assign hm1    = ROW_BITS'(height - HEIGHT_BITS'(1));
  assign ds     = $signed({(RNG_BITS+1-COST_BITS)'(0), d});
  assign lo_x   = (RNG_BITS+1)'(lo);
  assign hi_x   = (RNG_BITS+1)'(hi);
  assign rng_x  = hi_x - lo_x;
  assign diff_x = hi_x - ds;
  assign ge     = (num >= NUM_BITS'(dvs));

  always_ff @(posedge clk) begin
    if (rst) mstate <= MS_IDLE;
    else     mstate <= mstate_next;
  end

  always_comb begin
    mstate_next = mstate;
    case (mstate)
      MS_IDLE: begin
        if (start && !(ds < lo_x) && !(ds > hi_x) && (rng_x > 0)) mstate_next = MS_MUL;
      end
      MS_MUL:  mstate_next = MS_ADD;
      MS_ADD:  mstate_next = MS_DIV;
      MS_DIV: begin
        if (step == '0) mstate_next = MS_IDLE;
      end
      default: mstate_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      case (mstate)
        MS_IDLE: begin
          // out-of-view and empty-view cases finish at once
          done <= start && ((ds < lo_x) || (ds > hi_x) || !(rng_x > 0));
          if (start) begin
            if (ds < lo_x) begin
              row <= hm1;
            end else if (ds > hi_x) begin
              row <= '0;
            end else if (!(rng_x > 0)) begin
              row <= hm1;
            end
            diff  <= diff_x[RNG_BITS-1:0];
            rng_q <= rng_x[RNG_BITS-1:0];
          end
        end
        MS_MUL: begin
          done <= 1'b0;
          prod <= PROD_BITS'(diff) * PROD_BITS'(hm1);
        end
        MS_ADD: begin
          // num = 2*diff*(h-1) + rng, divisor 2*rng aligned to the top quotient bit
          done <= 1'b0;
          num  <= NUM_BITS'({prod, 1'b0}) + NUM_BITS'(rng_q);
          dvs  <= {rng_q, ROW_BITS'(0)};
          quo  <= '0;
          step <= STEP_BITS'(ROW_BITS - 1);
        end
        MS_DIV: begin
          if (ge) num <= num - NUM_BITS'(dvs);
          quo  <= {quo[ROW_BITS-2:0], ge};
          dvs  <= dvs >> 1;
          step <= step - STEP_BITS'(1);
          done <= (step == '0);
          if (step == '0) row <= {quo[ROW_BITS-2:0], ge};
        end
        default: done <= 1'b0;
      endcase
    end
  end

endmodule

FILE: src/scwa_core.sv
// back end: sample ring, window min/max tracking, view update and result output
// depends on scwa_pkg, scwa_result_if and scwa_rowmap
module scwa_core (
  input  logic            clk,
  input  logic            rst,
  input  scwa_pkg::cfg_t  cfg,
  input  logic            cfg_clear,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  scwa_pkg::cmd_t  cmd,
  scwa_result_if.source   res
);
  import scwa_pkg::*;

  localparam int RANGE_BITS = COST_BITS + 1;
  localparam int PRODV_BITS = RANGE_BITS + SCALE_BITS + 1;
  localparam int INFL_BITS  = PRODV_BITS - 8;
  localparam int WIDE_BITS  = 41;
  localparam int RING_BITS  = COST_BITS + 1;

  localparam logic signed [WIDE_BITS-1:0] VB_MAX = WIDE_BITS'((64'sd1 <<< (VIEW_BITS-1)) - 1);
  localparam logic signed [WIDE_BITS-1:0] VB_MIN = -WIDE_BITS'(64'sd1 <<< (VIEW_BITS-1));

  function automatic logic signed [VIEW_BITS-1:0] sat_view(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] r;
    r = v;
    if (v > VB_MAX) r = VB_MAX;
    if (v < VB_MIN) r = VB_MIN;
    return r[VIEW_BITS-1:0];
  endfunction

  core_state_t                  state;
  core_state_t                  state_next;
  core_state_t                  view_ret;
  cmd_t                         cur;

  logic [RING_BITS-1:0]         ring [MAX_WIDTH];
  logic [RING_BITS-1:0]         rd_data;
  logic                         rd_en;
  logic [IDX_BITS-1:0]          rd_addr;
  logic                         wr_en;
  logic [IDX_BITS-1:0]          wr_addr;

  logic [IDX_BITS-1:0]          head;
  logic [FILL_BITS-1:0]         fill;
  logic [COST_BITS-1:0]         lmin;
  logic [COST_BITS-1:0]         lmax;
  logic                         lmin_set;
  logic                         lmax_set;
  logic [COST_BITS-1:0]         gmin;
  logic [COST_BITS-1:0]         gmax;
  logic signed [VIEW_BITS-1:0]  view_lo;
  logic signed [VIEW_BITS-1:0]  view_hi;

  logic signed [RANGE_BITS-1:0] range_w;
  logic signed [RANGE_BITS-1:0] range_q;
  logic signed [PRODV_BITS-1:0] prodv;
  logic signed [PRODV_BITS-1:0] prodv_neg;
  logic signed [INFL_BITS-1:0]  infl_q;
  logic signed [WIDE_BITS-1:0]  infl_w;
  logic signed [WIDE_BITS-1:0]  ext_w;
  logic signed [WIDE_BITS-1:0]  half_w;
  logic signed [WIDE_BITS-1:0]  hi_w;
  logic signed [WIDE_BITS-1:0]  lo_w;

  logic [FILL_BITS-1:0]         scan_k;
  logic                         scan_issue;
  logic                         sv;
  logic                         sfirst;
  logic                         slast;
  logic [FILL_BITS-1:0]         ren_k;
  logic                         ren_last;
  logic [COST_BITS-1:0]         old_cost;
  logic [COST_BITS-1:0]         s_cost;
  logic                         rescan;
  logic                         lmin_upd;
  logic                         lmax_upd;

  logic                         map_go;
  logic                         map_start;
  logic [COST_BITS-1:0]         map_d;
  logic                         map_done;
  logic [ROW_BITS-1:0]          map_row;
  logic [ROW_BITS-1:0]          row_q;
  logic [ROW_BITS-1:0]          min_row_q;
  logic                         out_load;

  assign old_cost   = rd_data[RING_BITS-1:1];
  assign s_cost     = rd_data[RING_BITS-1:1];
  assign rescan     = (fill == FILL_BITS'(1)) || !((old_cost > lmin) && (old_cost < lmax));
  assign scan_issue = (scan_k < fill);
  assign ren_last   = (ren_k == fill - FILL_BITS'(1));
  assign lmin_upd   = (cur.cost < lmin) || !lmin_set;
  assign lmax_upd   = (cur.cost > lmax) || !lmax_set;

  // view: inflate the local span by the scale and centre it on the span
  assign range_w   = $signed({1'b0, lmax}) - $signed({1'b0, lmin});
  assign prodv_neg = -prodv;
  assign infl_w    = WIDE_BITS'(infl_q);
  assign ext_w     = infl_w - WIDE_BITS'(range_q);
  assign half_w    = ext_w[WIDE_BITS-1] ? -((-ext_w) >>> 1) : (ext_w >>> 1);
  assign hi_w      = $signed({(WIDE_BITS-COST_BITS)'(0), lmax}) + half_w;
  assign lo_w      = hi_w - infl_w;

  scwa_rowmap u_rowmap (
    .clk    (clk),
    .rst    (rst),
    .start  (map_start),
    .d      (map_d),
    .lo     (view_lo),
    .hi     (view_hi),
    .height (eff_height(cfg.height)),
    .done   (map_done),
    .row    (map_row)
  );

  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_addr] <= {cur.cost, cur.set};
    if (rd_en) rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head;
    wr_en      = 1'b0;
    wr_addr    = head + fill[IDX_BITS-1:0];
    map_start  = 1'b0;
    map_d      = cur.cost;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.op)
            OP_PUSH:   state_next = (fill >= eff_width(cfg.width)) ? ST_EV_RD : ST_PUSH_WR;
            OP_CLEAR:  state_next = ST_MAP_MIN;
            OP_RENDER: state_next = (fill == '0) ? ST_IDLE : ST_MAP_MIN;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_EV_RD: begin
        rd_en      = 1'b1;
        state_next = ST_EV_DEC;
      end
      ST_EV_DEC: begin
        if (!rescan)                          state_next = ST_PUSH_WR;
        else if (fill == FILL_BITS'(1))       state_next = ST_VIEW_MUL;
        else                                  state_next = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = head + scan_k[IDX_BITS-1:0];
        if (sv && slast) state_next = ST_VIEW_MUL;
      end
      ST_VIEW_MUL:  state_next = ST_VIEW_INFL;
      ST_VIEW_INFL: state_next = ST_VIEW_BND;
      ST_VIEW_BND:  state_next = view_ret;
      ST_PUSH_WR: begin
        wr_en      = 1'b1;
        state_next = (lmin_upd || lmax_upd) ? ST_VIEW_MUL : ST_MAP_ROW;
      end
      ST_MAP_ROW: begin
        map_start = !map_go;
        map_d     = cur.cost;
        if (map_done) state_next = (cur.op == OP_RENDER) ? ST_EMIT : ST_MAP_MIN;
      end
      ST_MAP_MIN: begin
        map_start = !map_go;
        map_d     = gmin;
        if (map_done) state_next = (cur.op == OP_RENDER) ? ST_REN_RD : ST_EMIT;
      end
      ST_REN_RD: begin
        rd_en      = 1'b1;
        rd_addr    = head + ren_k[IDX_BITS-1:0];
        state_next = ST_REN_WAIT;
      end
      ST_REN_WAIT: state_next = ST_MAP_ROW;
      ST_EMIT: begin
        if (!res.valid || res.ready) begin
          out_load   = 1'b1;
          state_next = ((cur.op == OP_RENDER) && !ren_last) ? ST_REN_RD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      lmin      <= '0;
      lmax      <= '0;
      lmin_set  <= 1'b0;
      lmax_set  <= 1'b0;
      gmin      <= '0;
      gmax      <= '0;
      view_lo   <= '0;
      view_hi   <= '0;
      map_go    <= 1'b0;
      sv        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      sv <= (state == ST_SCAN) && scan_issue;
      if (map_start)     map_go <= 1'b1;
      else if (map_done) map_go <= 1'b0;
      if (out_load)       res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            row_q <= '0;
            ren_k <= '0;
            if (cmd.op == OP_CLEAR) begin
              head     <= '0;
              fill     <= '0;
              lmin     <= '0;
              lmax     <= '0;
              lmin_set <= 1'b0;
              lmax_set <= 1'b0;
              gmin     <= cfg.gmin_seed;
              gmax     <= cfg.gmax_seed;
              view_lo  <= '0;
              view_hi  <= '0;
            end
          end
        end
        ST_EV_DEC: begin
          head     <= head + IDX_BITS'(1);
          fill     <= fill - FILL_BITS'(1);
          view_ret <= ST_PUSH_WR;
          scan_k   <= '0;
          if (rescan) begin
            lmin     <= '0;
            lmax     <= '0;
            lmin_set <= 1'b0;
            lmax_set <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_issue) scan_k <= scan_k + FILL_BITS'(1);
          sfirst <= (scan_k == '0);
          slast  <= (scan_k == fill - FILL_BITS'(1));
          if (sv) begin
            if (sfirst) begin
              lmin     <= s_cost;
              lmax     <= s_cost;
              lmin_set <= rd_data[0];
              lmax_set <= rd_data[0];
            end else if (s_cost < lmin) begin
              lmin     <= s_cost;
              lmin_set <= rd_data[0];
            end else if (s_cost > lmax) begin
              lmax     <= s_cost;
              lmax_set <= rd_data[0];
            end
          end
        end
        ST_VIEW_MUL: begin
          range_q <= range_w;
          prodv   <= PRODV_BITS'(range_w) * $signed({1'b0, cfg.scale});
        end
        ST_VIEW_INFL: begin
          // divide by 256, rounding half away from zero
          if (prodv[PRODV_BITS-1]) begin
            infl_q <= -INFL_BITS'((prodv_neg + PRODV_BITS'(128)) >>> 8);
          end else begin
            infl_q <= INFL_BITS'((prodv + PRODV_BITS'(128)) >>> 8);
          end
        end
        ST_VIEW_BND: begin
          view_hi <= sat_view(hi_w);
          view_lo <= sat_view(lo_w);
        end
        ST_PUSH_WR: begin
          fill     <= fill + FILL_BITS'(1);
          view_ret <= ST_MAP_ROW;
          if (lmin_upd) begin
            lmin     <= cur.cost;
            lmin_set <= cur.set;
          end
          if (lmax_upd) begin
            lmax     <= cur.cost;
            lmax_set <= cur.set;
          end
          if (cur.cost < gmin) gmin <= cur.cost;
          if (cur.cost > gmax) gmax <= cur.cost;
        end
        ST_MAP_ROW: begin
          if (map_done) row_q <= map_row;
        end
        ST_MAP_MIN: begin
          if (map_done) min_row_q <= map_row;
        end
        ST_REN_WAIT: cur.cost <= rd_data[RING_BITS-1:1];
        ST_EMIT: begin
          if (out_load) begin
            res.row             <= row_q;
            res.min_row         <= min_row_q;
            res.local_min_cost  <= lmin;
            res.local_max_cost  <= lmax;
            res.global_min_cost <= gmin;
            res.global_max_cost <= gmax;
            res.last            <= (cur.op != OP_RENDER) || ren_last;
            ren_k               <= ren_k + FILL_BITS'(1);
          end
        end
        default: ;
      endcase

      // a window width write restarts the chart
      if (cfg_clear) begin
        head     <= '0;
        fill     <= '0;
        lmin     <= '0;
        lmax     <= '0;
        lmin_set <= 1'b0;
        lmax_set <= 1'b0;
        gmin     <= cfg.gmin_seed;
        gmax     <= cfg.gmax_seed;
        view_lo  <= '0;
        view_hi  <= '0;
      end
    end
  end

endmodule

FILE: src/scwa_checker.sv
// port-level checks for the strip-chart autoscale block, bound to the top level
// depends on scwa_pkg
module scwa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [scwa_pkg::ADDR_BITS-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [scwa_pkg::COST_BITS-1:0] lmin,
  input logic [scwa_pkg::COST_BITS-1:0] lmax
);
  import scwa_pkg::*;

  // a stalled result word stays offered
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // window bounds never cross
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> lmin <= lmax)
    else $error("local min above local max");

  // a plot height write reads back on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[4:2] == REG_PLOT_HEIGHT)
    ##1 (paddr[4:2] == REG_PLOT_HEIGHT) && !$past(rst)
    |-> prdata[HEIGHT_BITS-1:0] == $past(pwdata[HEIGHT_BITS-1:0]))
    else $error("plot height readback mismatch");

endmodule

bind strip_chart_window_autoscale_unit scwa_checker u_scwa_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .lmin      (result.local_min_cost),
  .lmax      (result.local_max_cost)
);
